[hw/rtl/lcdpf_pkg.sv]
// Shared types and constants for the LCD pixel command formatter.
// Used by the front classifier, the command queue, the byte sequencer and the top level.
package lcdpf_pkg;

    // Controller opcodes
    localparam logic [7:0] OP_COLUMN     = 8'h2A;
    localparam logic [7:0] OP_PAGE       = 8'h2B;
    localparam logic [7:0] OP_RAMWRITE   = 8'h2C;
    localparam logic [7:0] OP_ACCESS_CTL = 8'h36;

    // Window bounds: x + 1 + offset stays below 2^9 for the default parameters
    localparam int BOUND_W  = 9;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 8;
    localparam int M_USER_W = 2;

    // Bit positions in m_tuser
    localparam int USER_IS_DATA   = 0;
    localparam int USER_FRAME_END = 1;

    typedef enum logic {
        KIND_PIXEL  = 1'b0,
        KIND_ROTATE = 1'b1
    } item_kind_t;

    // Sequencer steps; STEP_CMD0 is the first byte of either kind of item
    typedef enum logic [3:0] {
        STEP_CMD0,
        STEP_COL0_HI,
        STEP_COL0_LO,
        STEP_COL1_HI,
        STEP_COL1_LO,
        STEP_PAGE_CMD,
        STEP_ROW0_HI,
        STEP_ROW0_LO,
        STEP_ROW1_HI,
        STEP_ROW1_LO,
        STEP_RAMWR_CMD,
        STEP_COLOR_HI,
        STEP_COLOR_LO,
        STEP_ACC_DATA
    } step_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [7:0]         ctl_byte;
        logic [BOUND_W-1:0] col0;
        logic [BOUND_W-1:0] col1;
        logic [BOUND_W-1:0] row0;
        logic [BOUND_W-1:0] row1;
        logic [15:0]        color;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] access_ctl(input logic [1:0] orient);
        logic [7:0] b;
        unique case (orient)
            2'd0:    b = 8'b00001000;
            2'd1:    b = 8'b01101000;
            2'd2:    b = 8'b11001000;
            default: b = 8'b10101000;
        endcase
        return b;
    endfunction

endpackage

[hw/rtl/lcdpf_front.sv]
// Front end: accepts request words, tracks orientation, drops off-panel pixels
// and builds window descriptors for the queue. Depends on lcdpf_pkg.
module lcdpf_front #(
    parameter int PANEL_WIDTH   = 128,
    parameter int PANEL_HEIGHT  = 128,
    parameter int WINDOW_OFFSET = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[7:0], pos_y[15:8], pixel_color[31:16], rotation_request[39:32]
    input  logic [lcdpf_pkg::S_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                            s_tuser,
    input  lcdpf_pkg::queue_status_t        q_status,
    output logic                            push,
    output lcdpf_pkg::cmd_t                 push_cmd
);
    import lcdpf_pkg::*;

    localparam logic [7:0]         WIDTH8  = 8'(PANEL_WIDTH);
    localparam logic [7:0]         HEIGHT8 = 8'(PANEL_HEIGHT);
    localparam logic [BOUND_W-1:0] OFS     = BOUND_W'(WINDOW_OFFSET);

    logic [1:0]         orient_reg, orient_next;
    logic [7:0]         pos_x, pos_y, rot_req;
    logic [15:0]        color;
    logic [7:0]         vis_w, vis_h;
    logic [BOUND_W-1:0] x_ofs, y_ofs;
    logic               in_area, accept;

    assign pos_x   = s_tdata[7:0];
    assign pos_y   = s_tdata[15:8];
    assign color   = s_tdata[31:16];
    assign rot_req = s_tdata[39:32];

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    // only orientation 1 swaps the visible size
    assign vis_w   = (orient_reg == 2'd1) ? HEIGHT8 : WIDTH8;
    assign vis_h   = (orient_reg == 2'd1) ? WIDTH8 : HEIGHT8;
    assign x_ofs   = (orient_reg == 2'd1) ? OFS : '0;
    assign y_ofs   = (orient_reg == 2'd0) ? OFS : '0;
    assign in_area = (pos_x < vis_w) && (pos_y < vis_h);

    always_comb begin
        orient_next = orient_reg;
        if (accept && s_tuser == KIND_ROTATE) begin
            orient_next = rot_req[1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            orient_reg <= '0;
        end else begin
            orient_reg <= orient_next;
        end
    end

    assign push = accept && (s_tuser == KIND_ROTATE || in_area);

    always_comb begin
        push_cmd.kind     = item_kind_t'(s_tuser);
        push_cmd.ctl_byte = access_ctl(rot_req[1:0]);
        push_cmd.col0     = BOUND_W'(pos_x) + x_ofs;
        push_cmd.col1     = BOUND_W'(pos_x) + x_ofs + BOUND_W'(1);
        push_cmd.row0     = BOUND_W'(pos_y) + y_ofs;
        push_cmd.row1     = BOUND_W'(pos_y) + y_ofs + BOUND_W'(1);
        push_cmd.color    = color;
    end

endmodule

[hw/rtl/lcdpf_queue.sv]
// Two-entry descriptor queue between the front end and the byte sequencer.
// Depends on lcdpf_pkg.
module lcdpf_queue (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      push,
    input  lcdpf_pkg::cmd_t           push_cmd,
    input  logic                      pop,
    output lcdpf_pkg::cmd_t           head_cmd,
    output lcdpf_pkg::queue_status_t  status
);
    import lcdpf_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       entry_reg [DEPTH];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign status.full  = (count_reg == 2'(DEPTH));
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head_cmd     = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

[hw/rtl/lcdpf_back.sv]
// Back end: walks each queued descriptor byte by byte into the output register.
// Depends on lcdpf_pkg.
module lcdpf_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  lcdpf_pkg::cmd_t                 head_cmd,
    input  lcdpf_pkg::queue_status_t        q_status,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_byte
    output logic [lcdpf_pkg::M_DATA_W-1:0]  m_tdata,
    // is_data[0], frame_end[1]
    output logic [lcdpf_pkg::M_USER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import lcdpf_pkg::*;

    step_t      step_reg, step_next;
    logic       valid_reg;
    logic [7:0] byte_reg;
    logic [1:0] user_reg;
    logic       last_reg;

    logic       load;
    logic [7:0] byte_c;
    logic       is_data_c, fend_c, last_c;

    function automatic logic [7:0] hi_byte(input logic [BOUND_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[15:8];
    endfunction

    function automatic logic [7:0] lo_byte(input logic [BOUND_W-1:0] v);
        logic [15:0] w;
        w = 16'(v);
        return w[7:0];
    endfunction

    assign load = !q_status.empty && (!valid_reg || m_tready);

    always_comb begin
        step_next = step_reg;
        byte_c    = '0;
        is_data_c = 1'b1;
        fend_c    = 1'b0;
        last_c    = 1'b0;
        unique case (step_reg)
            STEP_CMD0: begin
                is_data_c = 1'b0;
                fend_c    = 1'b1;
                if (head_cmd.kind == KIND_ROTATE) begin
                    byte_c    = OP_ACCESS_CTL;
                    step_next = STEP_ACC_DATA;
                end else begin
                    byte_c    = OP_COLUMN;
                    step_next = STEP_COL0_HI;
                end
            end
            STEP_COL0_HI: begin
                byte_c    = hi_byte(head_cmd.col0);
                step_next = STEP_COL0_LO;
            end
            STEP_COL0_LO: begin
                byte_c    = lo_byte(head_cmd.col0);
                fend_c    = 1'b1;
                step_next = STEP_COL1_HI;
            end
            STEP_COL1_HI: begin
                byte_c    = hi_byte(head_cmd.col1);
                step_next = STEP_COL1_LO;
            end
            STEP_COL1_LO: begin
                byte_c    = lo_byte(head_cmd.col1);
                fend_c    = 1'b1;
                step_next = STEP_PAGE_CMD;
            end
            STEP_PAGE_CMD: begin
                byte_c    = OP_PAGE;
                is_data_c = 1'b0;
                fend_c    = 1'b1;
                step_next = STEP_ROW0_HI;
            end
            STEP_ROW0_HI: begin
                byte_c    = hi_byte(head_cmd.row0);
                step_next = STEP_ROW0_LO;
            end
            STEP_ROW0_LO: begin
                byte_c    = lo_byte(head_cmd.row0);
                fend_c    = 1'b1;
                step_next = STEP_ROW1_HI;
            end
            STEP_ROW1_HI: begin
                byte_c    = hi_byte(head_cmd.row1);
                step_next = STEP_ROW1_LO;
            end
            STEP_ROW1_LO: begin
                byte_c    = lo_byte(head_cmd.row1);
                fend_c    = 1'b1;
                step_next = STEP_RAMWR_CMD;
            end
            STEP_RAMWR_CMD: begin
                byte_c    = OP_RAMWRITE;
                is_data_c = 1'b0;
                fend_c    = 1'b1;
                step_next = STEP_COLOR_HI;
            end
            STEP_COLOR_HI: begin
                byte_c    = head_cmd.color[15:8];
                step_next = STEP_COLOR_LO;
            end
            STEP_COLOR_LO: begin
                byte_c    = head_cmd.color[7:0];
                fend_c    = 1'b1;
                last_c    = 1'b1;
                step_next = STEP_CMD0;
            end
            STEP_ACC_DATA: begin
                byte_c    = head_cmd.ctl_byte;
                fend_c    = 1'b1;
                last_c    = 1'b1;
                step_next = STEP_CMD0;
            end
            default: begin
                step_next = STEP_CMD0;
            end
        endcase
    end

    assign pop = load && last_c;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= STEP_CMD0;
            valid_reg <= 1'b0;
        end else begin
            if (load) begin
                step_reg  <= step_next;
                valid_reg <= 1'b1;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg                 <= byte_c;
            user_reg[USER_IS_DATA]   <= is_data_c;
            user_reg[USER_FRAME_END] <= fend_c;
            last_reg                 <= last_c;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = byte_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule

[hw/rtl/lcd_pixel_command_formatter.sv]
// An accepted item goes into the queue; its first byte then loads into the sequencer's
// single output register. Bytes leave at one byte per cycle while m_tready is high.
// A pixel is 13 bytes, a rotation 2; an off-panel pixel is dropped in its accept cycle.
// Up to two descriptors wait in the queue, so new items are taken while bytes stream out.
// Reset (aresetn low, synchronous) clears orientation to 0, empties the queue and the
// output register.
module lcd_pixel_command_formatter #(
    parameter int PANEL_WIDTH   = 128,
    parameter int PANEL_HEIGHT  = 128,
    parameter int WINDOW_OFFSET = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pos_x[7:0], pos_y[15:8], pixel_color[31:16], rotation_request[39:32]
    input  logic [lcdpf_pkg::S_DATA_W-1:0]  s_tdata,
    // mode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // line_byte
    output logic [lcdpf_pkg::M_DATA_W-1:0]  m_tdata,
    // is_data[0], frame_end[1]
    output logic [lcdpf_pkg::M_USER_W-1:0]  m_tuser,
    output logic                            m_tlast
);
    import lcdpf_pkg::*;

    cmd_t          push_cmd, head_cmd;
    queue_status_t q_status;
    logic          push, pop;

    lcdpf_front #(
        .PANEL_WIDTH   (PANEL_WIDTH),
        .PANEL_HEIGHT  (PANEL_HEIGHT),
        .WINDOW_OFFSET (WINDOW_OFFSET)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    lcdpf_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    lcdpf_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // command bytes are always single-byte frames
    a_cmd_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[USER_IS_DATA] |-> m_tuser[USER_FRAME_END])
        else $error("command byte without frame end");

    // the last word of an item closes its frame
    a_last_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser[USER_FRAME_END] && m_tuser[USER_IS_DATA])
        else $error("last word does not close a data frame");

    a_queue_status: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_status.full && q_status.empty))
        else $error("queue both full and empty");

    // a pop only ever retires a descriptor that is present
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

endmodule

[verif/lcd_pixel_command_formatter_test.sv]
// Self-checking testbench for lcd_pixel_command_formatter: pixel and rotation words in,
// panel command/data bytes out, checked against an in-bench predictor.
// Depends on lcdpf_pkg and the formatter RTL only.
`timescale 1ns / 1ps

module lcd_pixel_command_formatter_test;
    import lcdpf_pkg::*;

    localparam int PANEL_W     = 128;
    localparam int PANEL_H     = 128;
    localparam int OFFSET      = 32;
    localparam int KEPT_ITEMS  = 140;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       is_data;
        logic       frame_end;
        logic       last;
    } lcd_byte_t;

    // Predicts the panel byte stream and checks the bytes that come out
    class pixel_stream_scoreboard;
        lcd_byte_t   expected_bytes[$];
        lcd_byte_t   staged[$];
        logic [1:0]  orient;
        int unsigned mismatches;
        int unsigned bytes_checked;
        int unsigned pixels_drawn;
        int unsigned pixels_dropped;
        int unsigned rotations;

        function new();
            orient = 2'd0;
            mismatches = 0;
            bytes_checked = 0;
            pixels_drawn = 0;
            pixels_dropped = 0;
            rotations = 0;
        endfunction

        function void push_byte(logic [7:0] b, logic dat, logic fend);
            staged.push_back('{line_byte: b, is_data: dat, frame_end: fend, last: 1'b0});
        endfunction

        // 16-bit data words go high byte first, one two-byte frame
        function void push_word(logic [15:0] w);
            push_byte(w[15:8], 1'b1, 1'b0);
            push_byte(w[7:0], 1'b1, 1'b1);
        endfunction

        function int note_item(item_kind_t kind, logic [7:0] x, logic [7:0] y,
                               logic [15:0] color, logic [7:0] rot);
            int         n;
            logic [7:0] ctl;
            int         vis_w;
            int         vis_h;
            logic [15:0] xo;
            logic [15:0] yo;
            if (kind == KIND_ROTATE) begin
                orient = rot[1:0];
                case (orient)
                    2'd0:    ctl = 8'h08;
                    2'd1:    ctl = 8'h68;
                    2'd2:    ctl = 8'hC8;
                    default: ctl = 8'hA8;
                endcase
                push_byte(OP_ACCESS_CTL, 1'b0, 1'b1);
                push_byte(ctl, 1'b1, 1'b1);
                rotations++;
            end else begin
                // only orientation 1 swaps the visible size
                vis_w = (orient == 2'd1) ? PANEL_H : PANEL_W;
                vis_h = (orient == 2'd1) ? PANEL_W : PANEL_H;
                xo = (orient == 2'd1) ? 16'(OFFSET) : 16'd0;
                yo = (orient == 2'd0) ? 16'(OFFSET) : 16'd0;
                if (int'(x) >= vis_w || int'(y) >= vis_h) begin
                    pixels_dropped++;
                    return 0;
                end
                push_byte(OP_COLUMN, 1'b0, 1'b1);
                push_word({8'd0, x} + xo);
                push_word({8'd0, x} + 16'd1 + xo);
                push_byte(OP_PAGE, 1'b0, 1'b1);
                push_word({8'd0, y} + yo);
                push_word({8'd0, y} + 16'd1 + yo);
                push_byte(OP_RAMWRITE, 1'b0, 1'b1);
                push_word(color);
                pixels_drawn++;
            end
            staged[staged.size()-1].last = 1'b1;
            n = staged.size();
            foreach (staged[i]) expected_bytes.push_back(staged[i]);
            staged.delete();
            return n;
        endfunction

        function void check_byte(logic [7:0] b, logic dat, logic fend, logic lst);
            lcd_byte_t got;
            lcd_byte_t want;
            got = '{line_byte: b, is_data: dat, frame_end: fend, last: lst};
            bytes_checked++;
            if (expected_bytes.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected byte %02h is_data=%0b frame_end=%0b last=%0b",
                             b, dat, fend, lst);
                return;
            end
            want = expected_bytes.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("byte %0d: exp %02h/%0b/%0b/%0b got %02h/%0b/%0b/%0b",
                             bytes_checked, want.line_byte, want.is_data, want.frame_end,
                             want.last, got.line_byte, got.is_data, got.frame_end, got.last);
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [M_USER_W-1:0]  m_tuser;
    logic                 m_tlast;

    pixel_stream_scoreboard sb = new();

    bit hold_request = 1'b0;
    bit hold_active  = 1'b0;
    int stall_count  = 0;

    lcd_pixel_command_formatter #(
        .PANEL_WIDTH  (PANEL_W),
        .PANEL_HEIGHT (PANEL_H),
        .WINDOW_OFFSET(OFFSET)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    // mostly back-to-back or short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    // offer one word and hold it until accepted; returns the bytes it should cause
    task automatic send_item(input item_kind_t kind, input logic [7:0] x, input logic [7:0] y,
                             input logic [15:0] color, input logic [7:0] rot,
                             output int nbytes);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {rot, color, y, x};
        do @(posedge aclk); while (!s_tready);
        nbytes = sb.note_item(kind, x, y, color, rot);
    endtask

    task automatic idle_sender(input int gap);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_random(input int pct_rotate, input int pct_noise, output int nbytes);
        int r;
        r = $urandom_range(0, 99);
        if (r < pct_rotate)
            send_item(KIND_ROTATE, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                      nbytes);
        else if (r < pct_rotate + pct_noise)
            send_item(KIND_PIXEL, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom),
                      nbytes);
        else
            send_item(KIND_PIXEL, 8'($urandom_range(0, PANEL_W - 1)),
                      8'($urandom_range(0, PANEL_H - 1)), 16'($urandom), 8'($urandom),
                      nbytes);
    endtask

    task automatic wait_drained();
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    // watchdog: no handshake on either side for too long ends the run
    always @(posedge aclk) begin
        if (aresetn && !((s_tvalid && s_tready) || (m_tvalid && m_tready))) begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
                $display("[FAIL] regression broken");
                $finish;
            end
        end else begin
            stall_count <= 0;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tuser[USER_IS_DATA], m_tuser[USER_FRAME_END], m_tlast);
    end

    // receiver: random ready with runs of no idling, plus one long hold-off on request
    initial begin
        int gap;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                hold_active  = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_active = 1'b0;
            end
            m_tready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat (60) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            gap = pick_gap();
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
    end

    initial begin
        int n;
        int kept;
        int idx;
        bit ok;
        kept = 0;
        idx  = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // orientation 0 after reset: page offset, panel edges, off-panel drops
        send_item(KIND_PIXEL,  8'd0,   8'd0,   16'h0000, 8'hFF, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd127, 8'd127, 16'hFFFF, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd128, 8'd0,   16'h1234, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd0,   8'd128, 16'h4321, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd255, 8'd255, 16'hFFFF, 8'hFF, n); idle_sender(pick_gap());
        // orientation 1: column offset, swapped size
        send_item(KIND_ROTATE, 8'hFF,  8'hFF,  16'hFFFF, 8'h01, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd0,   8'd0,   16'hA5A5, 8'h02, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd127, 8'd127, 16'h5A5A, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd128, 8'd5,   16'h0F0F, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd5,   8'd128, 16'hF0F0, 8'h00, n); idle_sender(pick_gap());
        // orientation 2 and 3: no offset; upper request bits ignored; then back to orientation 0
        send_item(KIND_ROTATE, 8'h00,  8'h00,  16'h0000, 8'hFE, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd127, 8'd0,   16'h8001, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd0,   8'd127, 16'h7FFE, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd5,   8'd200, 16'h1111, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_ROTATE, 8'h12,  8'h34,  16'h5678, 8'h07, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd64,  8'd64,  16'h1234, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd127, 8'd127, 16'hFFFF, 8'hFF, n); idle_sender(pick_gap());
        send_item(KIND_ROTATE, 8'h00,  8'h00,  16'h0000, 8'hFF, n); idle_sender(pick_gap());
        send_item(KIND_ROTATE, 8'h00,  8'h00,  16'h0000, 8'h00, n); idle_sender(pick_gap());
        send_item(KIND_ROTATE, 8'hFF,  8'hFF,  16'hFFFF, 8'hFC, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd127, 8'd0,   16'h0001, 8'hFF, n); idle_sender(pick_gap());
        send_item(KIND_PIXEL,  8'd1,   8'd1,   16'hC3C3, 8'hFF, n); idle_sender(pick_gap());

        while (kept < KEPT_ITEMS) begin
            if (idx == 40) begin
                // receiver stalls long; sender keeps offering until the block backs up
                idle_sender(1);
                hold_request = 1'b1;
                while (!hold_active) @(posedge aclk);
                repeat (12) begin
                    send_random(0, 0, n);
                    if (n > 0) kept++;
                end
            end else if (idx == 90 || idx == 140) begin
                // sender pauses until the output side has caught up
                idle_sender(1);
                wait_drained();
            end else if (idx >= 110 && idx < 130) begin
                // back-to-back burst
                send_random(15, 10, n);
                if (n > 0) kept++;
            end else begin
                send_random(15, 15, n);
                if (n > 0) kept++;
                idle_sender(pick_gap());
            end
            idx++;
        end

        idle_sender(1);
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d pixels drawn, %0d off-panel drops, %0d rotations, %0d bytes",
                 sb.pixels_drawn, sb.pixels_dropped, sb.rotations, sb.bytes_checked);
        $display("with random gaps on both sides, a %0d-cycle output hold-off and drains",
                 HOLD_CYCLES);
        ok = (sb.mismatches == 0) && (sb.pending() == 0);
        if (ok) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches, %0d bytes outstanding", sb.mismatches, sb.pending());
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/lcdpf_pkg.sv
hw/rtl/lcdpf_front.sv
hw/rtl/lcdpf_queue.sv
hw/rtl/lcdpf_back.sv
hw/rtl/lcd_pixel_command_formatter.sv
verif/lcd_pixel_command_formatter_test.sv
